>>> rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants
// Calibration set, front-to-back request record and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpc_pkg;

   localparam int unsigned CALIB_W = 48;
   localparam int unsigned RAW_W   = 20;

   typedef enum logic [1:0] {
      REG_TEMP_CALIB    = 2'd0,
      REG_PRESS_CALIB_A = 2'd1,
      REG_PRESS_CALIB_B = 2'd2,
      REG_PRESS_CALIB_C = 2'd3
   } reg_index_type;

   // twelve calibration words, sign or zero extended to 32 bits
   typedef struct packed {
      logic [31:0] t1, t2, t3;
      logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
   } calib_type;

   // one request handed from the front to the back
   typedef struct packed {
      logic [RAW_W-1:0] raw_temperature;
      logic [RAW_W-1:0] raw_pressure;
   } sample_type;

   localparam logic [31:0] PRESS_OFFSET = 32'd64000;
   localparam logic [31:0] PRESS_FULL   = 32'd1048576;
   localparam logic [31:0] PRESS_SCALE  = 32'd3125;
   localparam logic [31:0] SIGN_BIT     = 32'h80000000;
   localparam logic [31:0] VAR1_BIAS    = 32'd32768;
   localparam logic [31:0] ROUND_HALF   = 32'd128;

   function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
      asr = 32'($signed(v) >>> n);
   endfunction

   function automatic logic [31:0] word_s(input logic [15:0] w);
      word_s = {{16{w[15]}}, w};
   endfunction

endpackage

>>> rtl/bpc_divider.sv
// ----------------------------------------------------------------------------
// bpc_divider: pipelined unsigned divider
// 32-bit restoring division, one quotient bit per stage, tag carried along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpc_divider #(
   parameter int unsigned TAG_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic             advance,
   input  logic [31:0]      dividend,
   input  logic [31:0]      divisor,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [31:0]      quotient,
   output logic [TAG_W-1:0] out_tag
);
   localparam int unsigned STAGES = 32;

   logic [STAGES:1]      vld_ff;
   logic [31:0]          rem_ff [1:STAGES];
   logic [31:0]          quo_ff [1:STAGES];
   logic [31:0]          den_ff [1:STAGES];
   logic [TAG_W-1:0]     tag_ff [1:STAGES];

   // one quotient bit per stage
   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic             v_cur;
      logic [31:0]      rem_cur, quo_cur, den_cur;
      logic [TAG_W-1:0] tag_cur;
      logic [32:0]      trial;
      logic [32:0]      shifted;

      // take the first stage from the ports, the others from the stage before
      if (s == 0) begin : g_head
         assign v_cur   = in_valid;
         assign rem_cur = '0;
         assign quo_cur = dividend;
         assign den_cur = divisor;
         assign tag_cur = in_tag;
      end else begin : g_link
         assign v_cur   = vld_ff[s];
         assign rem_cur = rem_ff[s];
         assign quo_cur = quo_ff[s];
         assign den_cur = den_ff[s];
         assign tag_cur = tag_ff[s];
      end

      assign shifted = {rem_cur, quo_cur[31]};
      assign trial   = shifted - {1'b0, den_cur};
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[s+1] <= v_cur;
         end
         if (advance) begin
            if (!trial[32]) begin
               rem_ff[s+1] <= trial[31:0];
               quo_ff[s+1] <= {quo_cur[30:0], 1'b1};
            end else begin
               rem_ff[s+1] <= shifted[31:0];
               quo_ff[s+1] <= {quo_cur[30:0], 1'b0};
            end
            den_ff[s+1] <= den_cur;
            tag_ff[s+1] <= tag_cur;
         end
      end
   end

   assign out_valid = vld_ff[STAGES];
   assign quotient  = quo_ff[STAGES];
   assign out_tag   = tag_ff[STAGES];
endmodule

>>> rtl/bpc_front.sv
// ----------------------------------------------------------------------------
// bpc_front: request intake
// Register requests into a two-entry queue that feeds the back part.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  bpc_pkg::sample_type in_data,
   output logic                q_valid,
   input  logic                q_ready,
   output bpc_pkg::sample_type q_data
);
   import bpc_pkg::*;

   sample_type  buf_ff [2];
   logic        wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_data   = buf_ff[rp_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   // advance queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         buf_ff[wp_ff] <= in_data;
      end
   end
endmodule

>>> rtl/bpc_back.sv
// ----------------------------------------------------------------------------
// bpc_back: compensation pipeline
// Stall-together pipeline of the temperature and pressure arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpc_back (
   input  logic                clock,
   input  logic                reset,
   input  bpc_pkg::calib_type  calib,
   input  logic                in_valid,
   output logic                in_ready,
   input  bpc_pkg::sample_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [31:0]         out_temp,
   output logic [31:0]         out_press,
   output logic                out_zero
);
   import bpc_pkg::*;

   localparam int unsigned NS = 11;
   localparam int unsigned TAG_W = 32 + 32 + 1;

   logic adv;
   logic [NS-1:0] v_ff;
   logic div_v;
   logic [31:0] div_q;
   logic [TAG_W-1:0] div_tag;
   logic [31:0] quo_in;

   // the whole pipe stalls when the last stage holds an untaken result
   assign adv      = !out_valid || out_ready;
   assign in_ready = adv;

   // per-stage payloads
   logic [19:0] s1_adp, s2_adp, s3_adp, s4_adp, s5_adp, s6_adp, s7_adp;
   logic [31:0] s1_ta, s1_d;
   logic [31:0] s2_a, s2_dd;
   logic [31:0] s3_a, s3_b;
   logic [31:0] s4_fine;
   logic [31:0] s5_temp, s5_pa, s5_qa;
   logic [31:0] s6_temp, s6_pa, s6_sq, s6_qa5, s6_p2a;
   logic [31:0] s7_temp, s7_b6, s7_p3sq, s7_a5, s7_p2a;
   logic [31:0] s8_temp, s8_b, s8_v1;
   logic [31:0] s9_temp, s9_b, s9_v1p;
   logic [19:0] s8_adp, s9_adp;
   logic [31:0] s10_temp, s10_num, s10_v1;
   logic [31:0] s11_temp, s11_num, s11_v1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NS-2:0], in_valid};
      end
   end

   // temperature and pressure stages
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_adp <= in_data.raw_pressure;
         s1_ta  <= {15'd0, in_data.raw_temperature[19:3]} - {calib.t1[30:0], 1'b0};
         s1_d   <= {16'd0, in_data.raw_temperature[19:4]} - calib.t1;
         s2_adp <= s1_adp;
         s2_a   <= asr(s1_ta * calib.t2, 11);
         s2_dd  <= asr(s1_d * s1_d, 12);
         s3_adp <= s2_adp;
         s3_a   <= s2_a;
         s3_b   <= asr(s2_dd * calib.t3, 14);
         s4_adp <= s3_adp;
         s4_fine <= s3_a + s3_b;
         s5_adp <= s4_adp;
         s5_temp <= asr(s4_fine * 32'd5 + ROUND_HALF, 8);
         s5_pa  <= asr(s4_fine, 1) - PRESS_OFFSET;
         s5_qa  <= asr(asr(s4_fine, 1) - PRESS_OFFSET, 2);
         s6_adp <= s5_adp;
         s6_temp <= s5_temp;
         s6_pa  <= s5_pa;
         s6_sq  <= s5_qa * s5_qa;
         s6_qa5 <= s5_pa * calib.p5;
         s6_p2a <= calib.p2 * s5_pa;
         s7_adp <= s6_adp;
         s7_temp <= s6_temp;
         s7_b6  <= asr(s6_sq, 11) * calib.p6;
         s7_p3sq <= calib.p3 * asr(s6_sq, 13);
         s7_a5  <= {s6_qa5[30:0], 1'b0};
         s7_p2a <= s6_p2a;
         s8_adp <= s7_adp;
         s8_temp <= s7_temp;
         s8_b   <= asr(s7_b6 + s7_a5, 2) + {calib.p4[15:0], 16'd0};
         s8_v1  <= asr(asr(s7_p3sq, 3) + asr(s7_p2a, 1), 18);
         s9_adp <= s8_adp;
         s9_temp <= s8_temp;
         s9_b   <= s8_b;
         s9_v1p <= (VAR1_BIAS + s8_v1) * calib.p1;
         s10_temp <= s9_temp;
         s10_num <= (PRESS_FULL - {12'd0, s9_adp}) - asr(s9_b, 12);
         s10_v1 <= asr(s9_v1p, 15);
         s11_temp <= s10_temp;
         s11_num <= s10_num * PRESS_SCALE;
         s11_v1  <= s10_v1;
      end
   end

   // dividend chosen so quotient matches both branches of the scheme
   logic [31:0] dvd;
   assign dvd = (s11_num < SIGN_BIT) ? {s11_num[30:0], 1'b0} : s11_num;

   bpc_divider #(.TAG_W(TAG_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v_ff[NS-1]),
      .advance  (adv),
      .dividend (dvd),
      .divisor  (s11_v1),
      .in_tag   ({s11_temp, s11_v1, s11_num < SIGN_BIT}),
      .out_valid(div_v),
      .quotient (div_q),
      .out_tag  (div_tag)
   );

   logic [31:0] t_temp, t_v1;
   logic        t_small;
   assign {t_temp, t_v1, t_small} = div_tag;
   assign quo_in = t_small ? div_q : {div_q[30:0], 1'b0};

   // correction stages
   logic [31:0] c1_temp, c1_p, c1_sq, c1_b;
   logic        c1_z;
   logic [31:0] c2_temp, c2_p, c2_a, c2_b;
   logic        c2_z;
   logic [31:0] c3_temp, c3_p;
   logic        c3_z;

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_temp <= t_temp;
         c1_z    <= (t_v1 == 32'd0);
         c1_p    <= quo_in;
         c1_sq   <= ({3'd0, quo_in[31:3]} * {3'd0, quo_in[31:3]}) >> 13;
         c1_b    <= asr({2'd0, quo_in[31:2]} * calib.p8, 13);
         c2_temp <= c1_temp;
         c2_z    <= c1_z;
         c2_p    <= c1_p;
         c2_a    <= asr(calib.p9 * c1_sq, 12);
         c2_b    <= c1_b;
         c3_temp <= c2_temp;
         c3_z    <= c2_z;
         c3_p    <= c2_z ? 32'd0 : c2_p + asr(c2_a + c2_b + calib.p7, 4);
      end
   end

   logic [2:0] cv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= '0;
      end else if (adv) begin
         cv_ff <= {cv_ff[1:0], div_v};
      end
   end

   assign out_valid = cv_ff[2];
   assign out_temp  = c3_temp;
   assign out_press = c3_p;
   assign out_zero  = c3_z;
endmodule

>>> rtl/barometric_pressure_compensation.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation: top level
// A request passes through the intake queue, 11 arithmetic stages,
// a 32-stage divider and 3 correction stages on its way to the result.
// Throughput one request per cycle unless an untaken response stalls the pipeline.
// Synchronous reset clears the pipeline valid flags and the calibration registers to 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module barometric_pressure_compensation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // temperature_centi[31:0], pressure_pa[63:32]
   output logic        rsp_tuser,   // zero_divisor
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import bpc_pkg::*;

   logic [CALIB_W-1:0] reg_ff [4];
   reg_index_type      idx;
   logic               wr;
   calib_type          calib;
   sample_type         in_s, q_s;
   logic               q_valid, q_ready;
   logic [31:0]        o_t, o_p;

   assign csr_pready = 1'b1;
   assign idx = reg_index_type'(csr_paddr[4:3]);
   assign wr  = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2:0] == 3'd0);
   assign csr_prdata = (csr_paddr[2:0] == 3'd0) ? {16'd0, reg_ff[idx]} : 64'd0;

   // write calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) reg_ff[i] <= '0;
      end else if (wr) begin
         reg_ff[idx] <= csr_pwdata[CALIB_W-1:0];
      end
   end

   always_comb begin
      calib.t1 = {16'd0, reg_ff[REG_TEMP_CALIB][15:0]};
      calib.t2 = word_s(reg_ff[REG_TEMP_CALIB][31:16]);
      calib.t3 = word_s(reg_ff[REG_TEMP_CALIB][47:32]);
      calib.p1 = {16'd0, reg_ff[REG_PRESS_CALIB_A][15:0]};
      calib.p2 = word_s(reg_ff[REG_PRESS_CALIB_A][31:16]);
      calib.p3 = word_s(reg_ff[REG_PRESS_CALIB_A][47:32]);
      calib.p4 = word_s(reg_ff[REG_PRESS_CALIB_B][15:0]);
      calib.p5 = word_s(reg_ff[REG_PRESS_CALIB_B][31:16]);
      calib.p6 = word_s(reg_ff[REG_PRESS_CALIB_B][47:32]);
      calib.p7 = word_s(reg_ff[REG_PRESS_CALIB_C][15:0]);
      calib.p8 = word_s(reg_ff[REG_PRESS_CALIB_C][31:16]);
      calib.p9 = word_s(reg_ff[REG_PRESS_CALIB_C][47:32]);
      in_s.raw_temperature = req_tdata[19:0];
      in_s.raw_pressure    = req_tdata[39:20];
   end

   bpc_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_data(in_s),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_s)
   );

   bpc_back u_back (
      .clock(clock), .reset(reset), .calib(calib),
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_s),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_temp(o_t), .out_press(o_p), .out_zero(rsp_tuser)
   );

   assign rsp_tdata = {o_p, o_t};
endmodule
